FILE: rtl/ofc64_pkg.sv
// Package for the object Fletcher-64 checker.
// Transaction structs, the modulus constants and the end-around-carry adder.
// No dependencies.
`default_nettype none

package ofc64_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned CHECK_W = 2 * WORD_W;

   localparam logic [WORD_W-1:0]  FL_MOD      = '1;
   localparam logic [CHECK_W-1:0] FL_ALL_ONES = '1;

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      logic              last_word;
   } req_type;

   typedef struct packed {
      logic [CHECK_W-1:0] computed_check;
      logic               check_passed;
      logic               stored_all_ones;
   } rsp_type;

   // final sums and stored checksum of one object, handed to the fold stage
   typedef struct packed {
      logic [WORD_W-1:0]  first_sum;
      logic [WORD_W-1:0]  second_sum;
      logic [CHECK_W-1:0] stored_check;
   } fold_type;

   // (a + b) mod 2^32-1, for a + b < 2 * (2^32-1) + 1
   function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      logic [WORD_W:0] sum;
      logic [WORD_W:0] inc;
      sum = {1'b0, a} + {1'b0, b};
      inc = sum + {{WORD_W{1'b0}}, 1'b1};
      return inc[WORD_W] ? inc[WORD_W-1:0] : sum[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ofc64_fold.sv
// Fold stage: turns the final running sums into the 64-bit check value
// and compares it with the stored checksum. Uses ofc64_pkg.
`default_nettype none

module ofc64_fold
   import ofc64_pkg::*;
(
   input  fold_type fold,
   output rsp_type  result
);

   logic [WORD_W-1:0] low_half;
   logic [WORD_W-1:0] high_half;
   logic              ones;

   // m - x is the complement of x for x in [0, m]
   assign low_half  = ~mod_add(fold.first_sum, fold.second_sum);
   assign high_half = ~mod_add(fold.first_sum, low_half);
   assign ones      = (fold.stored_check == FL_ALL_ONES);

   always_comb begin
      result.computed_check  = {high_half, low_half};
      result.check_passed    = !ones && ({high_half, low_half} == fold.stored_check);
      result.stored_all_ones = ones;
   end

endmodule

`default_nettype wire

FILE: rtl/object_fletcher64_checker.sv
// Top level of the object Fletcher-64 checker.
// Input register, running-sum stage, fold stage and result register.
// Uses ofc64_pkg and ofc64_fold.
`default_nettype none

// Takes one 32-bit word per cycle; words 0 and 1 of each object are the
// stored checksum (low first), later words feed two running sums mod 2^32-1.
// The word flagged last yields one result transaction, which goes through the
// fold register and the result register before rsp_valid rises; all other
// words yield none. The pipeline advances as a whole whenever the result
// register is empty or being taken, so the sustained rate is one word per
// cycle while rsp_stall is low. No clearing pass is needed after reset.
module object_fletcher64_checker
   import ofc64_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      POS_LOW,
      POS_HIGH,
      POS_DATA
   } pos_type;

   logic advance;

   logic              in_valid_ff;
   req_type           in_data_ff;

   pos_type           pos_ff,    pos_in;
   logic [WORD_W-1:0] first_ff,  first_in;
   logic [WORD_W-1:0] second_ff, second_in;
   logic [CHECK_W-1:0] stored_ff, stored_in;

   logic              fold_valid_ff;
   fold_type          fold_ff;
   rsp_type           fold_result;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // running-sum update for the word in the input register
   always_comb begin
      pos_in    = pos_ff;
      first_in  = first_ff;
      second_in = second_ff;
      stored_in = stored_ff;
      unique case (pos_ff)
         POS_LOW: begin
            stored_in[WORD_W-1:0] = in_data_ff.data_word;
            pos_in                = POS_HIGH;
         end
         POS_HIGH: begin
            stored_in[CHECK_W-1:WORD_W] = in_data_ff.data_word;
            pos_in                      = POS_DATA;
         end
         POS_DATA: begin
            first_in  = mod_add(first_ff, in_data_ff.data_word);
            second_in = mod_add(second_ff, first_in);
         end
         default: begin
            pos_in = POS_LOW;
         end
      endcase
   end

   ofc64_fold u_fold (
      .fold   (fold_ff),
      .result (fold_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         fold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= POS_LOW;
         first_ff      <= '0;
         second_ff     <= '0;
         stored_ff     <= '0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
         if (req_valid) begin
            in_data_ff <= req_data;
         end

         fold_valid_ff <= in_valid_ff && in_data_ff.last_word;
         if (in_valid_ff) begin
            if (in_data_ff.last_word) begin
               fold_ff.first_sum    <= first_in;
               fold_ff.second_sum   <= second_in;
               fold_ff.stored_check <= stored_in;
               pos_ff               <= POS_LOW;
               first_ff             <= '0;
               second_ff            <= '0;
               stored_ff            <= '0;
            end else begin
               pos_ff    <= pos_in;
               first_ff  <= first_in;
               second_ff <= second_in;
               stored_ff <= stored_in;
            end
         end

         rsp_valid_ff <= fold_valid_ff;
         if (fold_valid_ff) begin
            rsp_data_ff <= fold_result;
         end
      end
   end

   // running sums stay reduced below the modulus
   assert property (@(posedge clock) disable iff (reset)
      (first_ff != FL_MOD) && (second_ff != FL_MOD))
      else $error("running sum not reduced");

   // a last word leaves the sum stage cleared
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_data_ff.last_word) |=>
         (pos_ff == POS_LOW) && (first_ff == '0) && (second_ff == '0) && (stored_ff == '0))
      else $error("state not cleared after last word");

   // a folded object reaches the result register on the next advance
   assert property (@(posedge clock) disable iff (reset)
      (advance && fold_valid_ff) |=> rsp_valid_ff)
      else $error("folded result lost");

   // pass is never reported for an all-ones stored checksum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.check_passed && rsp_data_ff.stored_all_ones))
      else $error("pass with invalid stored checksum");

endmodule

`default_nettype wire
